/* hw/rtl/cltd_pkg.sv */
`timescale 1ns / 1ps
// Package for the coherent LRU cache tag directory.
// Opcodes, MSI codes, field widths and controller/datapath handshake structs.
package cltd_pkg;

	localparam int OPCODE_W  = 3;
	localparam int ADDR_W    = 32;
	localparam int REPLY_W   = 5;
	localparam int BCAST_W   = 2;
	localparam int LSTATE_W  = 2;
	localparam int CFG_W     = 4;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 16;

	localparam logic [OPCODE_W-1:0] OP_READ       = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_WRITE      = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_ACCESS     = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_SNOOP_INV  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_SNOOP_SHR  = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_PROBE_LD   = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_PROBE_ST   = 3'd6;

	localparam logic [LSTATE_W-1:0] ST_I = 2'd0;
	localparam logic [LSTATE_W-1:0] ST_S = 2'd1;
	localparam logic [LSTATE_W-1:0] ST_M = 2'd2;

	localparam logic [BCAST_W-1:0] BC_NONE  = 2'd0;
	localparam logic [BCAST_W-1:0] BC_INV   = 2'd1;
	localparam logic [BCAST_W-1:0] BC_SHARE = 2'd2;

	localparam logic [0:0] REG_MISS_DELAY = 1'b0;
	localparam logic [0:0] REG_PEER_COUNT = 1'b1;

	typedef struct packed {
		logic clear;
		logic capture;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} dp_status_t;

endpackage

/* hw/rtl/cltd_ctrl.sv */
`timescale 1ns / 1ps
// Controller for the tag directory: clearing sweep, capture and commit sequencing.
// Depends on cltd_pkg.
module cltd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cltd_pkg::dp_status_t status,
	output cltd_pkg::ctrl_cmd_t  cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_LOOK  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		cmd.clear   = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		in_ready    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) state_d = S_LOOK;
			end
			S_LOOK: begin
				cmd.commit = status.out_free;
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/cltd_dp.sv */
`timescale 1ns / 1ps
// Datapath for the tag directory: tag and metadata memories, lookup, LRU update, reply register.
// Depends on cltd_pkg.
module cltd_dp #(
	parameter int SETS       = 64,
	parameter int WAYS       = 4,
	parameter int LINE_BYTES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cltd_pkg::ctrl_cmd_t               cmd,
	output cltd_pkg::dp_status_t              status,
	input  logic [cltd_pkg::OPCODE_W-1:0]     in_opcode,
	input  logic [cltd_pkg::ADDR_W-1:0]       in_address,
	input  logic [cltd_pkg::CFG_W-1:0]        miss_delay,
	input  logic [cltd_pkg::CFG_W-1:0]        peer_count,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cltd_pkg::OUT_DATA_W-1:0]   out_data
);

	localparam int OFF  = $clog2(LINE_BYTES);
	localparam int TAGW = cltd_pkg::ADDR_W - OFF;
	localparam int SIW  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WIW  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int META_W = WAYS * (1 + 2 + WIW);

	typedef struct packed {
		logic [WAYS-1:0]          valid;
		logic [WAYS-1:0][1:0]     st;
		logic [WAYS-1:0][WIW-1:0] ord;
	} meta_t;

	logic [WAYS-1:0][TAGW-1:0] tag_mem [SETS];
	logic [META_W-1:0]         meta_mem [SETS];

	logic [WAYS-1:0][TAGW-1:0] tag_row_q;
	meta_t                     meta_row_q;
	logic [cltd_pkg::OPCODE_W-1:0] op_q;
	logic [TAGW-1:0]           line_q;
	logic [SIW-1:0]            set_q;
	logic [SIW-1:0]            clr_idx_q;
	logic                      out_valid_q;
	logic [cltd_pkg::OUT_DATA_W-1:0] out_data_q;

	meta_t                     meta_init;
	meta_t                     meta_new;
	logic [WAYS-1:0][TAGW-1:0] tag_new;
	logic                      found;
	logic [WIW-1:0]            pos;
	logic [WIW-1:0]            way;
	logic                      move;
	logic                      hit;
	logic [cltd_pkg::REPLY_W-1:0]  reply;
	logic [cltd_pkg::BCAST_W-1:0]  bc;
	logic [cltd_pkg::LSTATE_W-1:0] lstate;
	logic [1:0]                cs;
	logic                      peers;

	function automatic logic [SIW-1:0] set_of(input logic [cltd_pkg::ADDR_W-1:0] a);
		logic [TAGW-1:0] ln;
		logic [SIW:0]    raw;
		ln  = a[cltd_pkg::ADDR_W-1:OFF];
		raw = '0;
		if (SETS > 1) raw = {1'b0, ln[SIW-1:0]};
		if (raw >= (SIW+1)'(SETS)) raw = raw - (SIW+1)'(SETS);
		return raw[SIW-1:0];
	endfunction

	always_comb begin
		meta_init = '0;
		for (int p = 0; p < WAYS; p++) meta_init.ord[p] = WIW'(p);
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			meta_mem[clr_idx_q] <= meta_init;
		end else if (cmd.commit) begin
			meta_mem[set_q] <= meta_new;
			tag_mem[set_q]  <= tag_new;
		end
		if (cmd.capture) begin
			meta_row_q <= meta_mem[set_of(in_address)];
			tag_row_q  <= tag_mem[set_of(in_address)];
			op_q       <= in_opcode;
			line_q     <= in_address[cltd_pkg::ADDR_W-1:OFF];
			set_q      <= set_of(in_address);
		end
	end

	always_comb begin
		found = 1'b0;
		pos   = WIW'(WAYS - 1);
		for (int p = WAYS - 1; p >= 0; p--) begin
			if (meta_row_q.valid[meta_row_q.ord[p]] && tag_row_q[meta_row_q.ord[p]] == line_q) begin
				found = 1'b1;
				pos   = WIW'(p);
			end
		end
		way      = meta_row_q.ord[pos];
		cs       = meta_row_q.st[way];
		peers    = (peer_count != '0);
		meta_new = meta_row_q;
		tag_new  = tag_row_q;
		move     = 1'b0;
		hit      = 1'b0;
		reply    = '0;
		bc       = cltd_pkg::BC_NONE;
		lstate   = cltd_pkg::ST_I;
		case (op_q)
			cltd_pkg::OP_READ, cltd_pkg::OP_WRITE, cltd_pkg::OP_ACCESS: begin
				move = 1'b1;
				if (found) begin
					hit = 1'b1;
					if (op_q == cltd_pkg::OP_READ) begin
						reply = cltd_pkg::REPLY_W'(1);
						if (cs == cltd_pkg::ST_I) begin
							if (peers) bc = cltd_pkg::BC_SHARE;
							meta_new.st[way] = cltd_pkg::ST_S;
						end
					end else if (op_q == cltd_pkg::OP_WRITE) begin
						if (cs != cltd_pkg::ST_M) begin
							if (peers) bc = cltd_pkg::BC_INV;
							reply = cltd_pkg::REPLY_W'(peer_count);
							meta_new.st[way] = cltd_pkg::ST_M;
						end
					end
				end else begin
					meta_new.valid[way] = 1'b1;
					tag_new[way]        = line_q;
					if (op_q == cltd_pkg::OP_READ) begin
						meta_new.st[way] = cltd_pkg::ST_S;
						if (peers) bc = cltd_pkg::BC_SHARE;
					end else if (op_q == cltd_pkg::OP_WRITE) begin
						meta_new.st[way] = cltd_pkg::ST_M;
						if (peers) bc = cltd_pkg::BC_INV;
						reply = cltd_pkg::REPLY_W'(miss_delay) + cltd_pkg::REPLY_W'(peer_count);
					end else begin
						reply = cltd_pkg::REPLY_W'(miss_delay);
					end
				end
				lstate = meta_new.st[way];
			end
			cltd_pkg::OP_SNOOP_INV, cltd_pkg::OP_SNOOP_SHR: begin
				if (found) begin
					hit = 1'b1;
					meta_new.st[way] = (op_q == cltd_pkg::OP_SNOOP_INV) ? cltd_pkg::ST_I
					                                                    : cltd_pkg::ST_S;
					lstate = meta_new.st[way];
				end
			end
			cltd_pkg::OP_PROBE_LD, cltd_pkg::OP_PROBE_ST: begin
				if (found) begin
					lstate = cs;
					if ((cs == cltd_pkg::ST_M) ||
					    (op_q == cltd_pkg::OP_PROBE_LD && cs == cltd_pkg::ST_S)) begin
						hit   = 1'b1;
						reply = cltd_pkg::REPLY_W'(1);
						move  = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (move) begin
			for (int p = 1; p < WAYS; p++) begin
				if (WIW'(p) <= pos) meta_new.ord[p] = meta_row_q.ord[p-1];
			end
			meta_new.ord[0] = way;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) clr_idx_q <= clr_idx_q + 1'b1;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) out_data_q <= {6'd0, lstate, bc, reply, hit};
	end

	assign status.clear_last = (clr_idx_q == SIW'(SETS - 1));
	assign status.out_free   = !out_valid_q || out_ready;
	assign out_valid         = out_valid_q;
	assign out_data          = out_data_q;

endmodule

/* hw/rtl/coherent_lru_cache_tag_directory_top.sv */
`timescale 1ns / 1ps
// Top level of the coherent LRU cache tag directory: stream ports, APB registers.
// Depends on cltd_pkg, cltd_ctrl and cltd_dp.
//
// channel   direction  handshake               payload
// s_*       in         s_tvalid / s_tready     opcode, address
// m_*       out        m_tvalid / m_tready     hit, reply_value, broadcast, line_state
// apb       in         psel/penable/pready     miss_delay (0x0), peer_count (0x4)
//
// Each request is captured with the memory read, then looked up and written back; the write-back
// waits until the reply register is free. One request is in flight at a time; the set memories have a single port.
// After reset a clearing pass over every set runs before the first request is taken.
// A waiting reply does not block the next capture; it blocks only its commit.
module coherent_lru_cache_tag_directory_top #(
	parameter int SETS       = 64,
	parameter int WAYS       = 4,
	parameter int LINE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [2:0] opcode, [34:3] address
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] hit, [5:1] reply_value, [7:6] broadcast, [9:8] line_state
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cltd_pkg::ctrl_cmd_t  cmd;
	cltd_pkg::dp_status_t status;
	logic [cltd_pkg::CFG_W-1:0] miss_delay_q;
	logic [cltd_pkg::CFG_W-1:0] peer_count_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_delay_q <= 4'd2;
			peer_count_q <= 4'd0;
		end else if (cfg_wr) begin
			if (paddr[2] == cltd_pkg::REG_MISS_DELAY) miss_delay_q <= pwdata[3:0];
			else peer_count_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == cltd_pkg::REG_MISS_DELAY) ? {28'd0, miss_delay_q}
	                                                       : {28'd0, peer_count_q};

	cltd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cltd_dp #(
		.SETS       (SETS),
		.WAYS       (WAYS),
		.LINE_BYTES (LINE_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_opcode  (s_tdata[2:0]),
		.in_address (s_tdata[34:3]),
		.miss_delay (miss_delay_q),
		.peer_count (peer_count_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken during lookup");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && paddr[2] == cltd_pkg::REG_MISS_DELAY) |=> miss_delay_q == $past(pwdata[3:0]))
		else $error("miss_delay write lost");

	a_bcast_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:6] != 2'd3)
		else $error("illegal broadcast code");

	a_no_bcast_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && peer_count_q == 4'd0 && $stable(peer_count_q)) |-> m_tdata[7:6] == 2'd0)
		else $error("broadcast with no peers");

endmodule

/* tb/coherent_lru_cache_tag_directory_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for the coherent LRU cache tag directory: stream requests in, replies out,
// checked against a behavioral tag/LRU/MSI predictor. Depends on cltd_pkg and the top level.
module coherent_lru_cache_tag_directory_top_tb;

	localparam int NSETS = 64;
	localparam int NWAYS = 4;

	typedef struct packed {
		logic [cltd_pkg::OPCODE_W-1:0] opcode;
		logic [cltd_pkg::ADDR_W-1:0]   address;
	} req_t;

	typedef struct packed {
		logic                          hit;
		logic [cltd_pkg::REPLY_W-1:0]  reply_value;
		logic [cltd_pkg::BCAST_W-1:0]  broadcast;
		logic [cltd_pkg::LSTATE_W-1:0] line_state;
	} reply_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [cltd_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [cltd_pkg::OUT_DATA_W-1:0] m_tdata;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	coherent_lru_cache_tag_directory_top DUT (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	logic [25:0]                   tags [NSETS][NWAYS];
	logic                          vld  [NSETS][NWAYS];
	logic [cltd_pkg::LSTATE_W-1:0] msi  [NSETS][NWAYS];
	int                            order[NSETS][NWAYS];
	logic [3:0]                    miss_delay_q, peer_count_q;

	req_t   pending_reqs[$];
	reply_t expected_replies[$];
	int     errors = 0;
	int     sent = 0;
	bit     hold_off = 0;
	bit     stim_done = 0;
	int     gap_cnt = 0, stall_cnt = 0, hold_cnt = 0;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic reply_t predict_lookup(req_t q);
		reply_t rp;
		logic [25:0] line;
		int set, pos, w, e;
		logic [cltd_pkg::LSTATE_W-1:0] cs;
		bit ok;
		rp = '0;
		line = q.address[31:6];
		set = q.address[11:6];
		pos = -1;
		for (int p = 0; p < NWAYS; p++) begin
			w = order[set][p];
			if (pos < 0 && vld[set][w] && tags[set][w] == line) pos = p;
		end
		case (q.opcode)
			cltd_pkg::OP_READ, cltd_pkg::OP_WRITE, cltd_pkg::OP_ACCESS: begin
				if (pos >= 0) begin
					e = order[set][pos];
					rp.hit = 1;
					if (q.opcode == cltd_pkg::OP_READ) begin
						rp.reply_value = 1;
						if (msi[set][e] == cltd_pkg::ST_I) begin
							if (peer_count_q != 0) rp.broadcast = cltd_pkg::BC_SHARE;
							msi[set][e] = cltd_pkg::ST_S;
						end
					end else if (q.opcode == cltd_pkg::OP_WRITE &&
					             msi[set][e] != cltd_pkg::ST_M) begin
						if (peer_count_q != 0) rp.broadcast = cltd_pkg::BC_INV;
						rp.reply_value = peer_count_q;
						msi[set][e] = cltd_pkg::ST_M;
					end
				end else begin
					pos = NWAYS - 1;
					e = order[set][pos];
					vld[set][e] = 1;
					tags[set][e] = line;
					if (q.opcode == cltd_pkg::OP_READ) begin
						msi[set][e] = cltd_pkg::ST_S;
						if (peer_count_q != 0) rp.broadcast = cltd_pkg::BC_SHARE;
					end else if (q.opcode == cltd_pkg::OP_WRITE) begin
						msi[set][e] = cltd_pkg::ST_M;
						if (peer_count_q != 0) rp.broadcast = cltd_pkg::BC_INV;
						rp.reply_value = miss_delay_q + peer_count_q;
					end else
						rp.reply_value = miss_delay_q;
				end
				for (int p = pos; p > 0; p--) order[set][p] = order[set][p-1];
				order[set][0] = e;
				rp.line_state = msi[set][e];
			end
			cltd_pkg::OP_SNOOP_INV, cltd_pkg::OP_SNOOP_SHR: begin
				if (pos >= 0) begin
					e = order[set][pos];
					rp.hit = 1;
					msi[set][e] = (q.opcode == cltd_pkg::OP_SNOOP_INV) ? cltd_pkg::ST_I
					                                                   : cltd_pkg::ST_S;
					rp.line_state = msi[set][e];
				end
			end
			cltd_pkg::OP_PROBE_LD, cltd_pkg::OP_PROBE_ST: begin
				if (pos >= 0) begin
					e = order[set][pos];
					cs = msi[set][e];
					ok = (q.opcode == cltd_pkg::OP_PROBE_LD) ?
						(cs == cltd_pkg::ST_M || cs == cltd_pkg::ST_S) : (cs == cltd_pkg::ST_M);
					rp.line_state = cs;
					if (ok) begin
						rp.hit = 1;
						rp.reply_value = 1;
						for (int p = pos; p > 0; p--) order[set][p] = order[set][p-1];
						order[set][0] = e;
					end
				end
			end
			default: ;
		endcase
		return rp;
	endfunction

	// input handshake sampled at the posedge
	logic in_acc = 0;
	req_t in_req;
	always @(posedge clk) begin
		in_acc <= s_tvalid && s_tready;
		in_req <= {s_tdata[2:0], s_tdata[34:3]};
	end

	// driver
	always @(negedge clk) begin
		if (in_acc) begin
			expected_replies.push_back(predict_lookup(in_req));
			sent <= sent + 1;
		end
		if (!s_tvalid || in_acc) begin
			if (gap_cnt > 0) begin
				gap_cnt <= gap_cnt - 1;
				s_tvalid <= 0;
			end else if (pending_reqs.size() > 0) begin
				req_t q;
				q = pending_reqs.pop_front();
				s_tdata <= {5'b0, q.address, q.opcode};
				s_tvalid <= 1;
				gap_cnt <= gap_len();
			end else
				s_tvalid <= 0;
		end
	end

	// sampled at the posedge, handled at the negedge so the prediction is already queued
	logic got_reply;
	logic [15:0] got_data;
	always @(posedge clk) begin
		got_reply <= m_tvalid && m_tready;
		got_data <= m_tdata;
	end

	// monitor
	always @(negedge clk) begin
		if (got_reply) begin
			reply_t act, exp_r;
			act = {got_data[0], got_data[5:1], got_data[7:6], got_data[9:8]};
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected reply %h", $time, act);
				errors++;
			end else begin
				exp_r = expected_replies.pop_front();
				if (act.hit !== exp_r.hit) begin
					$display("%0t: hit exp %0d got %0d", $time, exp_r.hit, act.hit);
					errors++;
				end
				if (act.reply_value !== exp_r.reply_value) begin
					$display("%0t: reply_value exp %0d got %0d", $time,
						exp_r.reply_value, act.reply_value);
					errors++;
				end
				if (act.broadcast !== exp_r.broadcast) begin
					$display("%0t: broadcast exp %0d got %0d", $time,
						exp_r.broadcast, act.broadcast);
					errors++;
				end
				if (act.line_state !== exp_r.line_state) begin
					$display("%0t: line_state exp %0d got %0d", $time,
						exp_r.line_state, act.line_state);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 0;
		end else if (hold_off) begin
			hold_cnt <= 200;
			m_tready <= 0;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			m_tready <= 0;
		end else begin
			m_tready <= 1;
			if ($urandom_range(0, 3) == 0) stall_cnt <= gap_len();
		end
	end

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data; penable <= 0;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		if (addr == {cltd_pkg::REG_MISS_DELAY, 2'b00}) miss_delay_q = data[3:0];
		else peer_count_q = data[3:0];
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic drain();
		int budget;
		budget = 0;
		while ((pending_reqs.size() > 0 || s_tvalid || expected_replies.size() > 0)
			&& budget < 200000) begin
			@(posedge clk);
			budget++;
		end
		repeat (10) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_addr();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return {$urandom_range(0, 5) == 0 ? 20'($urandom) : 20'($urandom_range(0, 5)),
				6'($urandom_range(0, 3)), 6'($urandom)};
		return $urandom;
	endfunction

	task automatic add(input logic [cltd_pkg::OPCODE_W-1:0] op, input logic [31:0] a);
		req_t q;
		q.opcode = op;
		q.address = a;
		pending_reqs.push_back(q);
	endtask

	initial begin
		for (int s = 0; s < NSETS; s++)
			for (int w = 0; w < NWAYS; w++) begin
				vld[s][w] = 0; msi[s][w] = cltd_pkg::ST_I; order[s][w] = w; tags[s][w] = '0;
			end
		miss_delay_q = 2;
		peer_count_q = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		repeat (NSETS + 4) @(negedge clk);

		// directed: miss fill, hits, valid-in-I, probes, snoops, LRU eviction
		add(cltd_pkg::OP_READ, 32'h0000_0000);
		add(cltd_pkg::OP_READ, 32'h0000_0000);
		add(cltd_pkg::OP_WRITE, 32'h0000_0000);
		add(cltd_pkg::OP_PROBE_ST, 32'h0000_0000);
		add(cltd_pkg::OP_SNOOP_SHR, 32'h0000_0000);
		add(cltd_pkg::OP_PROBE_ST, 32'h0000_0000);
		add(cltd_pkg::OP_SNOOP_INV, 32'h0000_0000);
		add(cltd_pkg::OP_PROBE_LD, 32'h0000_0000);
		add(cltd_pkg::OP_READ, 32'h0000_0000);
		add(cltd_pkg::OP_SNOOP_INV, 32'h0000_0000);
		add(cltd_pkg::OP_WRITE, 32'h0000_0000);
		add(cltd_pkg::OP_ACCESS, 32'hFFFF_FFFF);
		add(cltd_pkg::OP_PROBE_LD, 32'hFFFF_FFFF);
		add(cltd_pkg::OP_ACCESS, 32'h0000_1000);
		add(cltd_pkg::OP_ACCESS, 32'h0000_2000);
		add(cltd_pkg::OP_ACCESS, 32'h0000_3000);
		add(cltd_pkg::OP_ACCESS, 32'h0000_4000);
		add(cltd_pkg::OP_PROBE_LD, 32'h0000_5000);
		add(cltd_pkg::OP_SNOOP_SHR, 32'h0000_6000);
		add(3'd7, 32'hFFFF_FFFF);
		add(cltd_pkg::OP_WRITE, 32'hFFFF_FFC0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_reg(3'd0, 32'd15); write_reg(3'd4, 32'd15); end
				1: begin write_reg(3'd0, 32'd0); write_reg(3'd4, 32'd0); end
				2: begin write_reg(3'd0, 32'hFFFF_FFF7); write_reg(3'd4, 32'd1); end
				3: begin write_reg(3'd0, $urandom); write_reg(3'd4, $urandom); end
				default: begin write_reg(3'd0, 32'd2); write_reg(3'd4, 32'd9); end
			endcase
			for (int i = 0; i < 86; i++)
				add(3'($urandom_range(0, 15) == 0 ? 7 : $urandom_range(0, 6)), rand_addr());
			if (ph == 1) begin
				hold_off = 1;
				wait (hold_cnt > 0);
				hold_off = 0;
			end
			drain();
		end
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		repeat (20) @(negedge clk);
		if (errors == 0 && expected_replies.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#12ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/cltd_pkg.sv
hw/rtl/cltd_ctrl.sv
hw/rtl/cltd_dp.sv
hw/rtl/coherent_lru_cache_tag_directory_top.sv
tb/coherent_lru_cache_tag_directory_top_tb.sv
